/* design/assert_macros.svh */
// Assertion macros used by the escape-time iterator sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define FTI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by an expression.
`define FTI_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`else

`define FTI_ASSERT(label, clk, rst, prop, msg)
`define FTI_ASSERT_NEXT(label, clk, rst, cond, expr, msg)

`endif

`endif

/* design/fti_pkg.sv */
// Shared types, constants and saturation helper for the escape-time iterator.
package fti_pkg;

   // Screen and iteration bounds.
   localparam int WIDTH_DEFAULT      = 1024;
   localparam int HEIGHT_DEFAULT     = 1024;
   localparam int ITER_LIMIT_DEFAULT = 4096;

   // Field widths.
   localparam int COORD_W     = 10;
   localparam int COUNT_W     = 12;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_MODE      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_RE   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_IM   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_RE = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_IM = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT     = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ITER  = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SHIFT     = 8'd7;

   // Register reset values.
   localparam logic        RST_MODE      = 1'b0;
   localparam logic [30:0] RST_STEP_RE   = 31'd1048576;
   localparam logic [30:0] RST_STEP_IM   = 31'd1048576;
   localparam logic [31:0] RST_ORIGIN_RE = 32'hE000_0000;
   localparam logic [31:0] RST_ORIGIN_IM = 32'hE000_0000;
   localparam logic [30:0] RST_LIMIT     = 31'd1073741824;
   localparam logic [11:0] RST_MAX_ITER  = 12'd50;
   localparam logic [31:0] RST_SHIFT     = 32'h0000_0000;

   // Julia constant parts in Q4.28: -0.7 and 0.27015.
   localparam logic signed [31:0] JULIA_RE_Q = -32'sd187904819;
   localparam logic signed [31:0] JULIA_IM_Q = 32'sd72517838;

   // Fractal modes.
   localparam logic MODE_MANDELBROT = 1'b0;
   localparam logic MODE_JULIA      = 1'b1;

   // Saturation bounds of the Q4.28 word.
   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   // Configuration as seen by the sequencer.
   typedef struct packed {
      logic               mode;
      logic [30:0]        step_re;
      logic [30:0]        step_im;
      logic signed [31:0] origin_re;
      logic signed [31:0] origin_im;
      logic [30:0]        escape_limit;
      logic [11:0]        max_iter;
      logic signed [31:0] julia_shift;
   } cfg_type;

   // Clamp a wide sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* design/fti_csr.sv */
// Configuration register file of the escape-time iterator.
module fti_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fti_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fti_pkg::CSR_DATA_W-1:0]  csr_data,
   output fti_pkg::cfg_type                cfg
);
   import fti_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index and mask the data to the register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MODE:      cfg_in.mode         = csr_data[0];
            REG_STEP_RE:   cfg_in.step_re      = csr_data[30:0];
            REG_STEP_IM:   cfg_in.step_im      = csr_data[30:0];
            REG_ORIGIN_RE: cfg_in.origin_re    = csr_data;
            REG_ORIGIN_IM: cfg_in.origin_im    = csr_data;
            REG_LIMIT:     cfg_in.escape_limit = csr_data[30:0];
            REG_MAX_ITER:  cfg_in.max_iter     = csr_data[11:0];
            REG_SHIFT:     cfg_in.julia_shift  = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load defaults on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= RST_MODE;
         cfg_ff.step_re      <= RST_STEP_RE;
         cfg_ff.step_im      <= RST_STEP_IM;
         cfg_ff.origin_re    <= RST_ORIGIN_RE;
         cfg_ff.origin_im    <= RST_ORIGIN_IM;
         cfg_ff.escape_limit <= RST_LIMIT;
         cfg_ff.max_iter     <= RST_MAX_ITER;
         cfg_ff.julia_shift  <= RST_SHIFT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/fti_mul.sv */
// Shared signed 32x32 multiplier with a registered product.
module fti_mul (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [31:0] mul_b,
   output logic signed [63:0] mul_prod
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   // Form the full product.
   assign prod_in  = mul_a * mul_b;
   assign mul_prod = prod_ff;

   // Register the product every cycle.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* design/fti_seq.sv */
// Sequencer and datapath: pixel mapping, z = z^2 + c iteration, result register.
module fti_seq #(
   parameter int WIDTH      = fti_pkg::WIDTH_DEFAULT,
   parameter int HEIGHT     = fti_pkg::HEIGHT_DEFAULT,
   parameter int ITER_LIMIT = fti_pkg::ITER_LIMIT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fti_pkg::cfg_type            cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fti_pkg::COORD_W-1:0] px,
   input  logic [fti_pkg::COORD_W-1:0] py,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [fti_pkg::COUNT_W-1:0] iter_count,
   output logic                        escaped,
   output logic signed [31:0]          mul_a,
   output logic signed [31:0]          mul_b,
   input  logic signed [63:0]          mul_prod
);
   import fti_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_RE,
      ST_MAP_IM,
      ST_MAP_END,
      ST_ITER_RR,
      ST_ITER_II,
      ST_ITER_RI,
      ST_ITER_UPD,
      ST_FINISH
   } state_type;

   state_type            state_ff,  state_in;
   logic [COORD_W-1:0]   x_ff,      x_in;
   logic [COORD_W-1:0]   y_ff,      y_in;
   logic [COUNT_W-1:0]   cap_ff,    cap_in;
   logic [COUNT_W-1:0]   n_ff,      n_in;
   logic signed [31:0]   pre_ff,    pre_in;
   logic signed [31:0]   zr_ff,     zr_in;
   logic signed [31:0]   zi_ff,     zi_in;
   logic signed [31:0]   cr_ff,     cr_in;
   logic signed [31:0]   ci_ff,     ci_in;
   logic signed [35:0]   rr_ff,     rr_in;
   logic signed [35:0]   ii_ff,     ii_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_esc_ff,   rsp_esc_in;

   logic signed [31:0]   map_val;
   logic signed [36:0]   ri2;
   logic signed [37:0]   mag_sum;
   logic signed [37:0]   limit_ext;
   logic signed [63:0]   re_sum;
   logic signed [63:0]   im_sum;
   logic signed [31:0]   julia_re;
   logic signed [31:0]   julia_im;
   logic                 out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign iter_count = rsp_count_ff;
   assign escaped    = rsp_esc_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Feed the shared multiplier according to the step.
   always_comb begin
      case (state_ff)
         ST_MAP_RE: begin
            mul_a = {22'd0, x_ff};
            mul_b = {1'b0, cfg.step_re};
         end
         ST_MAP_IM: begin
            mul_a = {22'd0, y_ff};
            mul_b = {1'b0, cfg.step_im};
         end
         ST_ITER_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_ITER_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   // Pixel mapping: product plus the origin of the current axis.
   assign map_val = sat32(mul_prod + ((state_ff == ST_MAP_IM) ?
                                      64'(cfg.origin_re) : 64'(cfg.origin_im)));

   // Julia constant with shift.
   assign julia_re = sat32(64'(JULIA_RE_Q) + 64'(cfg.julia_shift));
   assign julia_im = sat32(64'(JULIA_IM_Q) + 64'(cfg.julia_shift));

   // Iteration terms; dropping low bits rounds toward minus infinity.
   assign ri2       = mul_prod[63:27];
   assign mag_sum   = {{2{rr_ff[35]}}, rr_ff} + {{2{ii_ff[35]}}, ii_ff};
   assign limit_ext = {7'd0, cfg.escape_limit};
   assign re_sum    = 64'(rr_ff) - 64'(ii_ff) + 64'(cr_ff);
   assign im_sum    = 64'(ri2) + 64'(ci_ff);

   // Step the sequencer.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cap_in       = cap_ff;
      n_in         = n_ff;
      pre_in       = pre_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_esc_in   = rsp_esc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in   = (32'(px) >= 32'(WIDTH))  ? COORD_W'(WIDTH - 1)  : px;
               y_in   = (32'(py) >= 32'(HEIGHT)) ? COORD_W'(HEIGHT - 1) : py;
               cap_in = (32'(cfg.max_iter) > 32'(ITER_LIMIT)) ?
                        COUNT_W'(ITER_LIMIT) : cfg.max_iter;
               n_in     = '0;
               state_in = ST_MAP_RE;
            end
         end
         ST_MAP_RE: begin
            state_in = ST_MAP_IM;
         end
         ST_MAP_IM: begin
            pre_in   = map_val;
            state_in = ST_MAP_END;
         end
         ST_MAP_END: begin
            if (cfg.mode == MODE_JULIA) begin
               zr_in = pre_ff;
               zi_in = map_val;
               cr_in = julia_re;
               ci_in = julia_im;
            end else begin
               zr_in = '0;
               zi_in = '0;
               cr_in = pre_ff;
               ci_in = map_val;
            end
            state_in = ST_ITER_RR;
         end
         ST_ITER_RR: begin
            state_in = (n_ff >= cap_ff) ? ST_FINISH : ST_ITER_II;
         end
         ST_ITER_II: begin
            rr_in    = mul_prod[63:28];
            state_in = ST_ITER_RI;
         end
         ST_ITER_RI: begin
            ii_in    = mul_prod[63:28];
            state_in = ST_ITER_UPD;
         end
         ST_ITER_UPD: begin
            if (mag_sum >= limit_ext) begin
               state_in = ST_FINISH;
            end else begin
               zr_in    = sat32(re_sum);
               zi_in    = sat32(im_sum);
               n_in     = n_ff + 1'b1;
               state_in = ST_ITER_RR;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = n_ff;
               rsp_esc_in   = (n_ff < cfg.max_iter);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, working registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         cap_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         cap_ff       <= cap_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      pre_ff       <= pre_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      rr_ff        <= rr_in;
      ii_ff        <= ii_in;
      rsp_count_ff <= rsp_count_in;
      rsp_esc_ff   <= rsp_esc_in;
   end

   // The count stays within the cap while a pixel is in flight.
   `FTI_ASSERT(a_count_capped, clock, reset, (state_ff == ST_IDLE) || (n_ff <= cap_ff), "iteration count above cap")
   // An update step advances the count by at most one.
   `FTI_ASSERT_NEXT(a_count_step, clock, reset, state_ff == ST_ITER_UPD, (n_ff == $past(n_ff)) || (n_ff == $past(n_ff) + 1'b1), "count jumped")
   // A new result only comes from the finish step.
   `FTI_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH), "result loaded outside finish")

endmodule

/* design/escape_time_fractal_iterator.sv */
// Top level of the escape-time fractal iterator (Mandelbrot / Julia).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   req     | in        | req_tvalid/req_tready  | tdata: px, py
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata: iter_count; tuser: escaped
//   csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One pixel runs through the mapping steps MAP_RE, MAP_IM and MAP_END, then the
// iterations and a finish step; each iteration issues three products through the
// single shared 32x32 multiplier plus one update step.
// The request side is ready only while no pixel is in flight; a finished result
// waits in the output register, so the next request is taken while it stalls.
// Reset is synchronous and restores the register defaults; csr writes are
// always taken.
module escape_time_fractal_iterator #(
   parameter int WIDTH      = fti_pkg::WIDTH_DEFAULT,
   parameter int HEIGHT     = fti_pkg::HEIGHT_DEFAULT,
   parameter int ITER_LIMIT = fti_pkg::ITER_LIMIT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,   // [9:0] px, [19:10] py
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // [11:0] iter_count
   output logic                            rsp_tuser,   // [0] escaped
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fti_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fti_pkg::CSR_DATA_W-1:0]  csr_data
);
   import fti_pkg::*;

   cfg_type            cfg;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] mul_prod;
   logic [COUNT_W-1:0] iter_count;

   fti_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fti_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   fti_seq #(
      .WIDTH      (WIDTH),
      .HEIGHT     (HEIGHT),
      .ITER_LIMIT (ITER_LIMIT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .px         (req_tdata[9:0]),
      .py         (req_tdata[19:10]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .iter_count (iter_count),
      .escaped    (rsp_tuser),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_prod   (mul_prod)
   );

   // Pack the count, pad to whole bytes.
   assign rsp_tdata = {4'd0, iter_count};

endmodule
